/* hw/rtl/oidlt_pkg.sv */
// Shared constants for the ordered ID set linked table.
// Holds field widths, operation codes and the default table depth.
// Depends on nothing; imported by the core.
package oidlt_pkg;

    localparam int DEFAULT_MAX_IDS = 256;
    localparam int ID_W            = 32;
    localparam int HANDLE_W        = 32;
    localparam int MODE_W          = 4;

    localparam logic [MODE_W-1:0] MODE_REG     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_UNREG   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_FIRST   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_NEXT    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ISREG   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_READCTR = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SETCTR  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_TRACK   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_UNTRACK = 4'd9;
    localparam logic [MODE_W-1:0] MODE_FIND    = 4'd10;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 4'd11;
    localparam logic [MODE_W-1:0] MODE_COUNT   = 4'd12;

endpackage

/* hw/rtl/oidlt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for the per-ID entry store of the linked table.
module oidlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/ordered_id_set_linked_table_core.sv */
// Flow: first, counter, count and unused codes go straight from idle to the response state;
// lookups and track/untrack/find pass through the evaluate state; register may add the tail
// update, unregister the predecessor and successor updates, and clear sweeps every entry.
// One transaction is in flight at a time and in_ready returns in the same cycle that the
// result is registered; the response state waits while the output is held by out_ready.
// Reset (rst_n, asynchronous, active low) clears control state, then sweeps every RAM entry.
module ordered_id_set_linked_table_core #(
    parameter int MAX_IDS = oidlt_pkg::DEFAULT_MAX_IDS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [oidlt_pkg::MODE_W-1:0]  mode,
    input  logic [oidlt_pkg::ID_W-1:0]    target_id,
    input  logic [oidlt_pkg::HANDLE_W-1:0] agent_handle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [oidlt_pkg::ID_W-1:0]    value,
    output logic [oidlt_pkg::HANDLE_W-1:0] handle_out
);

    import oidlt_pkg::*;

    // Each ID owns one RAM entry holding its registered and tracked flags, the
    // links to its neighbors in insertion order, and its attached handle.
    localparam int IDW       = $clog2(MAX_IDS);
    localparam int E_HND_LSB = 0;
    localparam int E_PRV_LSB = HANDLE_W;
    localparam int E_NXT_LSB = HANDLE_W + IDW;
    localparam int E_TRK     = HANDLE_W + 2 * IDW;
    localparam int E_REG     = E_TRK + 1;
    localparam int ENT_W     = E_REG + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_TAIL,
        S_PREV,
        S_NEXT,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [IDW-1:0]      clr_idx_reg, clr_idx_next;
    logic                clr_resp_reg, clr_resp_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [IDW-1:0]      id_reg, id_next;
    logic                id_ok_reg, id_ok_next;
    logic [HANDLE_W-1:0] hnd_reg, hnd_next;
    logic [IDW-1:0]      lnk_p_reg, lnk_p_next;
    logic [IDW-1:0]      lnk_n_reg, lnk_n_next;
    logic [IDW-1:0]      head_reg, head_next;
    logic [IDW-1:0]      tail_reg, tail_next;
    logic [IDW-1:0]      count_reg, count_next;
    logic [ID_W-1:0]     ctr_reg, ctr_next;
    logic                res_ok_reg, res_ok_next;
    logic [ID_W-1:0]     res_val_reg, res_val_next;
    logic [HANDLE_W-1:0] res_hnd_reg, res_hnd_next;
    logic                out_valid_reg, out_valid_next;
    logic                ok_reg, ok_next;
    logic [ID_W-1:0]     value_reg, value_next;
    logic [HANDLE_W-1:0] handle_out_reg, handle_out_next;

    logic                mem_we;
    logic [IDW-1:0]      mem_waddr;
    logic [ENT_W-1:0]    mem_wdata;
    logic [IDW-1:0]      mem_raddr;
    logic [ENT_W-1:0]    mem_rdata;

    logic                e_reg;
    logic                e_trk;
    logic [IDW-1:0]      e_next;
    logic [IDW-1:0]      e_prev;
    logic [HANDLE_W-1:0] e_hnd;
    logic                in_id_ok;
    logic [ID_W-1:0]     nxt_val;

    oidlt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_IDS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign e_reg  = mem_rdata[E_REG];
    assign e_trk  = mem_rdata[E_TRK];
    assign e_next = mem_rdata[E_NXT_LSB +: IDW];
    assign e_prev = mem_rdata[E_PRV_LSB +: IDW];
    assign e_hnd  = mem_rdata[E_HND_LSB +: HANDLE_W];

    // An ID is usable only if it is nonzero and below the table depth.
    assign in_id_ok = (target_id != '0) && (target_id < ID_W'(MAX_IDS));
    assign nxt_val  = (id_ok_reg && e_reg) ? ID_W'(e_next) : '0;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign value      = value_reg;
    assign handle_out = handle_out_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        clr_resp_next   = clr_resp_reg;
        mode_next       = mode_reg;
        id_next         = id_reg;
        id_ok_next      = id_ok_reg;
        hnd_next        = hnd_reg;
        lnk_p_next      = lnk_p_reg;
        lnk_n_next      = lnk_n_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        ctr_next        = ctr_reg;
        res_ok_next     = res_ok_reg;
        res_val_next    = res_val_reg;
        res_hnd_next    = res_hnd_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ok_next         = ok_reg;
        value_next      = value_reg;
        handle_out_next = handle_out_reg;

        mem_we    = 1'b0;
        mem_waddr = id_reg;
        mem_wdata = '0;
        mem_raddr = target_id[IDW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                // One entry per cycle: zero the whole entry, flags, links and handle.
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
                if (clr_idx_reg == IDW'(MAX_IDS - 1))
                begin
                    clr_idx_next  = '0;
                    clr_resp_next = 1'b0;
                    state_next    = clr_resp_reg ? S_RESP : S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    // The entry of target_id is read on this edge for the next state.
                    mode_next    = mode;
                    id_next      = target_id[IDW-1:0];
                    id_ok_next   = in_id_ok;
                    hnd_next     = agent_handle;
                    res_ok_next  = 1'b0;
                    res_val_next = '0;
                    res_hnd_next = '0;
                    state_next   = S_RESP;
                    case (mode)
                        MODE_REG, MODE_UNREG, MODE_NEXT, MODE_ISREG,
                        MODE_TRACK, MODE_UNTRACK, MODE_FIND:
                        begin
                            state_next = S_EVAL;
                        end
                        MODE_FIRST:
                        begin
                            res_val_next = ID_W'(head_reg);
                            res_ok_next  = (head_reg != '0);
                        end
                        MODE_ALLOC:
                        begin
                            res_val_next = ctr_reg;
                            if (ctr_reg != '1)
                            begin
                                ctr_next    = ctr_reg + 1'b1;
                                res_ok_next = 1'b1;
                            end
                        end
                        MODE_READCTR:
                        begin
                            res_val_next = ctr_reg;
                            res_ok_next  = 1'b1;
                        end
                        MODE_SETCTR:
                        begin
                            ctr_next     = target_id;
                            res_val_next = target_id;
                            res_ok_next  = 1'b1;
                        end
                        MODE_CLEAR:
                        begin
                            head_next     = '0;
                            tail_next     = '0;
                            count_next    = '0;
                            ctr_next      = ID_W'(1);
                            clr_idx_next  = '0;
                            clr_resp_next = 1'b1;
                            res_ok_next   = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        MODE_COUNT:
                        begin
                            res_val_next = ID_W'(count_reg);
                            res_ok_next  = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_EVAL:
            begin
                state_next = S_RESP;
                case (mode_reg)
                    MODE_REG:
                    begin
                        if (id_ok_reg && !e_reg)
                        begin
                            // Append at the tail; the old tail gets its next link next cycle.
                            mem_we      = 1'b1;
                            mem_wdata   = {1'b1, 1'b0, {IDW{1'b0}}, tail_reg, {HANDLE_W{1'b0}}};
                            mem_raddr   = tail_reg;
                            lnk_p_next  = tail_reg;
                            tail_next   = id_reg;
                            count_next  = count_reg + 1'b1;
                            res_ok_next = 1'b1;
                            if (tail_reg != '0)
                            begin
                                state_next = S_TAIL;
                            end
                            else
                            begin
                                head_next = id_reg;
                            end
                        end
                    end
                    MODE_UNREG:
                    begin
                        if (id_ok_reg && e_reg)
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = '0;
                            lnk_p_next  = e_prev;
                            lnk_n_next  = e_next;
                            res_ok_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            if (e_prev != '0)
                            begin
                                mem_raddr  = e_prev;
                                state_next = S_PREV;
                            end
                            else
                            begin
                                head_next = e_next;
                                if (e_next != '0)
                                begin
                                    mem_raddr  = e_next;
                                    state_next = S_NEXT;
                                end
                                else
                                begin
                                    tail_next = '0;
                                end
                            end
                        end
                    end
                    MODE_NEXT:
                    begin
                        res_val_next = nxt_val;
                        res_ok_next  = (nxt_val != '0);
                    end
                    MODE_ISREG:
                    begin
                        res_ok_next = id_ok_reg && e_reg;
                    end
                    MODE_TRACK:
                    begin
                        if ((hnd_reg != '0) && id_ok_reg && e_reg)
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = {e_reg, 1'b1, e_next, e_prev, hnd_reg};
                            res_ok_next = 1'b1;
                        end
                    end
                    MODE_UNTRACK:
                    begin
                        if (id_ok_reg && e_trk)
                        begin
                            mem_we       = 1'b1;
                            mem_wdata    = {e_reg, 1'b0, e_next, e_prev, e_hnd};
                            res_hnd_next = e_hnd;
                            res_ok_next  = 1'b1;
                        end
                    end
                    MODE_FIND:
                    begin
                        if (id_ok_reg && e_trk)
                        begin
                            res_hnd_next = e_hnd;
                            res_ok_next  = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_TAIL:
            begin
                // Old tail entry is on the read port; point it at the new ID.
                mem_we     = 1'b1;
                mem_waddr  = lnk_p_reg;
                mem_wdata  = {e_reg, e_trk, id_reg, e_prev, e_hnd};
                state_next = S_RESP;
            end

            S_PREV:
            begin
                // Predecessor skips over the removed ID.
                mem_we    = 1'b1;
                mem_waddr = lnk_p_reg;
                mem_wdata = {e_reg, e_trk, lnk_n_reg, e_prev, e_hnd};
                if (lnk_n_reg != '0)
                begin
                    mem_raddr  = lnk_n_reg;
                    state_next = S_NEXT;
                end
                else
                begin
                    tail_next  = lnk_p_reg;
                    state_next = S_RESP;
                end
            end

            S_NEXT:
            begin
                // Successor points back at the removed ID's predecessor.
                mem_we     = 1'b1;
                mem_waddr  = lnk_n_reg;
                mem_wdata  = {e_reg, e_trk, e_next, lnk_p_reg, e_hnd};
                state_next = S_RESP;
            end

            S_RESP:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    ok_next         = res_ok_reg;
                    value_next      = res_val_reg;
                    handle_out_next = res_hnd_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            clr_resp_reg   <= 1'b0;
            mode_reg       <= '0;
            id_reg         <= '0;
            id_ok_reg      <= 1'b0;
            hnd_reg        <= '0;
            lnk_p_reg      <= '0;
            lnk_n_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            ctr_reg        <= ID_W'(1);
            res_ok_reg     <= 1'b0;
            res_val_reg    <= '0;
            res_hnd_reg    <= '0;
            out_valid_reg  <= 1'b0;
            ok_reg         <= 1'b0;
            value_reg      <= '0;
            handle_out_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            clr_resp_reg   <= clr_resp_next;
            mode_reg       <= mode_next;
            id_reg         <= id_next;
            id_ok_reg      <= id_ok_next;
            hnd_reg        <= hnd_next;
            lnk_p_reg      <= lnk_p_next;
            lnk_n_reg      <= lnk_n_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            ctr_reg        <= ctr_next;
            res_ok_reg     <= res_ok_next;
            res_val_reg    <= res_val_next;
            res_hnd_reg    <= res_hnd_next;
            out_valid_reg  <= out_valid_next;
            ok_reg         <= ok_next;
            value_reg      <= value_next;
            handle_out_reg <= handle_out_next;
        end
    end

endmodule
